### sv/mrssd_pkg.sv
// Shared types, codes and glyph table for the multi-radix seven-segment display.
// Used by every module of the block; depends on nothing.
package mrssd_pkg;

    localparam int DIGIT_COUNT = 4;

    // Command codes
    localparam logic CMD_SHOW  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    // Number format codes
    localparam logic [2:0] FMT_HEX = 3'd1;
    localparam logic [2:0] FMT_DEC = 3'd2;
    localparam logic [2:0] FMT_OCT = 3'd3;
    localparam logic [2:0] FMT_BIN = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_RANGE  = 2'd1;
    localparam logic [1:0] ERR_FORMAT = 2'd2;

    // Digit positions, leftmost first
    localparam logic [2:0] POS_1 = 3'd1;
    localparam logic [2:0] POS_2 = 3'd2;
    localparam logic [2:0] POS_3 = 3'd3;
    localparam logic [2:0] POS_4 = 3'd4;

    // Segment constants
    localparam logic [7:0] SEG_POINT = 8'h80;
    localparam logic [7:0] GLYPH_E   = 8'h79;
    localparam logic [7:0] GLYPH_R   = 8'h50;

    // Range limits
    localparam logic [15:0] LIMIT_DEC = 16'd9999;

    typedef struct packed {
        logic        cmd;
        logic [15:0] number;
        logic [2:0]  position;
        logic        point_on;
    } in_word_t;

    typedef struct packed {
        logic [7:0] digit1_segments;
        logic [7:0] digit2_segments;
        logic [7:0] digit3_segments;
        logic [7:0] digit4_segments;
        logic [1:0] error_code;
    } out_word_t;

    // Four patterns, index 0 is the leftmost digit
    typedef logic [DIGIT_COUNT-1:0][7:0] patterns_t;

    // Result of the radix split: glyphs for a show-number command
    typedef struct packed {
        patterns_t  glyphs;
        logic [1:0] err;
    } split_t;

    // Map a digit value 0..15 to segments a..g
    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] g;
        case (d)
            4'h0: g = 8'h3F;
            4'h1: g = 8'h06;
            4'h2: g = 8'h5B;
            4'h3: g = 8'h4F;
            4'h4: g = 8'h66;
            4'h5: g = 8'h6D;
            4'h6: g = 8'h7D;
            4'h7: g = 8'h07;
            4'h8: g = 8'h7F;
            4'h9: g = 8'h6F;
            4'hA: g = 8'h77;
            4'hB: g = 8'h7C;
            4'hC: g = 8'h39;
            4'hD: g = 8'h5E;
            4'hE: g = 8'h79;
            default: g = 8'h71;
        endcase
        return g;
    endfunction

endpackage

### sv/multi_radix_seven_segment_display.sv
// Multi-radix seven-segment display: four digit patterns with decimal points.
// A word accepted into the input register moves on to the result register once that register is free.
// Throughput: one word per cycle; the input register keeps taking words while a
// result waits, and stalls only when both the input and result registers are full.
// Reset (aresetn low, synchronous): patterns all off, format hex, both registers empty.
// Uses mrssd_pkg, mrssd_split and mrssd_update.
module multi_radix_seven_segment_display
    import mrssd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_word_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_data,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata
);

    logic [2:0] fmt_reg;
    in_word_t   in_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    patterns_t  pat_reg;
    patterns_t  pat_next;
    out_word_t  out_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [1:0] err;
    split_t     split;
    logic       advance;
    logic       accept;

    mrssd_split u_split (
        .number        (in_reg.number),
        .number_format (fmt_reg),
        .split         (split)
    );

    mrssd_update u_update (
        .in_word       (in_reg),
        .patterns      (pat_reg),
        .split         (split),
        .patterns_next (pat_next),
        .err           (err)
    );

    // Handshake: move the held word to the result register when it is free
    always_comb begin
        advance        = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready        = !in_valid_reg || advance;
        accept         = s_valid && s_ready;
        in_valid_next  = accept || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg       <= FMT_HEX;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pat_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                fmt_reg <= cfg_wdata;
            end
            if (advance) begin
                pat_reg <= pat_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg.digit1_segments <= pat_next[0];
            out_reg.digit2_segments <= pat_next[1];
            out_reg.digit3_segments <= pat_next[2];
            out_reg.digit4_segments <= pat_next[3];
            out_reg.error_code      <= err;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### sv/mrssd_split.sv
// Radix split: turns a 16-bit number into four glyphs in the configured format.
// Uses mrssd_pkg; purely combinational, feeds mrssd_update.
module mrssd_split
    import mrssd_pkg::*;
(
    input  logic [15:0] number,
    input  logic [2:0]  number_format,
    output split_t      split
);

    typedef struct packed {
        logic [3:0]  digit;
        logic [13:0] rem;
    } dec_t;

    // Pick one decimal digit by parallel compares against its multiples
    function automatic dec_t dec_step(input logic [13:0] v, input logic [13:0] w);
        dec_t r;
        r.digit = 4'd0;
        r.rem   = v;
        for (int k = 1; k <= 9; k++) begin
            if (v >= 14'(k) * w) begin
                r.digit = 4'(k);
                r.rem   = v - 14'(k) * w;
            end
        end
        return r;
    endfunction

    dec_t                         dec_th;
    dec_t                         dec_hu;
    dec_t                         dec_te;
    logic [DIGIT_COUNT-1:0][3:0]  digits;
    logic [1:0]                   err;

    // Decimal digits, thousands first; only meaningful when in range
    always_comb begin
        dec_th = dec_step(number[13:0], 14'd1000);
        dec_hu = dec_step(dec_th.rem, 14'd100);
        dec_te = dec_step(dec_hu.rem, 14'd10);
    end

    // Select digits and range check for the active format
    always_comb begin
        digits = '0;
        err    = ERR_NONE;
        case (number_format)
            FMT_HEX: begin
                digits = {number[3:0], number[7:4], number[11:8], number[15:12]};
            end
            FMT_DEC: begin
                digits = {dec_te.rem[3:0], dec_te.digit, dec_hu.digit, dec_th.digit};
                if (number > LIMIT_DEC) begin
                    err = ERR_RANGE;
                end
            end
            FMT_OCT: begin
                digits = {1'b0, number[2:0], 1'b0, number[5:3],
                          1'b0, number[8:6], 1'b0, number[11:9]};
                if (number[15:12] != 4'd0) begin
                    err = ERR_RANGE;
                end
            end
            FMT_BIN: begin
                digits = {3'd0, number[0], 3'd0, number[1], 3'd0, number[2], 3'd0, number[3]};
                if (number[15:4] != 12'd0) begin
                    err = ERR_RANGE;
                end
            end
            default: begin
                err = ERR_FORMAT;
            end
        endcase
    end

    // Build glyphs, or the error message
    always_comb begin
        split.err = err;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            split.glyphs[i] = glyph(digits[i]);
        end
        if (err != ERR_NONE) begin
            split.glyphs[0] = GLYPH_E;
            split.glyphs[1] = GLYPH_R;
            split.glyphs[2] = GLYPH_R;
            split.glyphs[3] = glyph({2'b00, err});
        end
    end

endmodule

### sv/mrssd_update.sv
// Next-state logic for the four digit patterns and the error code of one word.
// Uses mrssd_pkg; takes the split result from mrssd_split.
module mrssd_update
    import mrssd_pkg::*;
(
    input  in_word_t   in_word,
    input  patterns_t  patterns,
    input  split_t     split,
    output patterns_t  patterns_next,
    output logic [1:0] err
);

    logic [7:0] sel;
    logic       hit;
    logic [1:0] idx;

    // Decode the point position; out-of-range positions leave the patterns alone
    always_comb begin
        hit = 1'b1;
        idx = 2'd0;
        unique case (in_word.position)
            POS_1:   idx = 2'd0;
            POS_2:   idx = 2'd1;
            POS_3:   idx = 2'd2;
            POS_4:   idx = 2'd3;
            default: hit = 1'b0;
        endcase
    end

    // Apply the command
    always_comb begin
        patterns_next = patterns;
        err           = ERR_NONE;
        sel           = in_word.point_on ? (patterns[idx] | SEG_POINT)
                                         : (patterns[idx] & ~SEG_POINT);
        if (in_word.cmd == CMD_SHOW) begin
            patterns_next = split.glyphs;
            err           = split.err;
        end else if (hit) begin
            patterns_next[idx] = sel;
        end
    end

endmodule

### sv/mrssd_checker.sv
// Port-level checker for the multi-radix seven-segment display, bound to the top.
// Uses mrssd_pkg; watches the handshake and result word only.
module mrssd_checker
    import mrssd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // Result register comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Input backpressure only when a result is waiting and not taken
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting result");

    // Error results always show Err with points clear
    a_err_glyph: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != ERR_NONE |->
            m_data.digit1_segments == GLYPH_E && m_data.digit2_segments == GLYPH_R &&
            m_data.digit3_segments == GLYPH_R && m_data.digit4_segments[7] == 1'b0)
        else $error("error result without Err pattern");

    // Only defined error codes appear
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.error_code != 2'd3)
        else $error("undefined error code");

endmodule

bind multi_radix_seven_segment_display mrssd_checker u_mrssd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### dv/multi_radix_seven_segment_display_tb.sv
// Self-checking testbench for the multi-radix seven-segment display block.
// Drives display commands and format writes, predicts every result word in place
// and checks it; depends on mrssd_pkg and multi_radix_seven_segment_display.
`timescale 1ns / 1ps

module multi_radix_seven_segment_display_tb;
    import mrssd_pkg::*;

    localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on either side
    localparam int SETTLE_CYCLES = 4;     // pause after the last result before a format write
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off for the pressure test

    // Format codes the block does not know
    localparam logic [2:0] FMT_UNK0 = 3'd0;
    localparam logic [2:0] FMT_UNK5 = 3'd5;
    localparam logic [2:0] FMT_UNK6 = 3'd6;
    localparam logic [2:0] FMT_UNK7 = 3'd7;

    // Positions that must leave the patterns alone
    localparam logic [2:0] POS_NONE = 3'd0;
    localparam logic [2:0] POS_5    = 3'd5;
    localparam logic [2:0] POS_7    = 3'd7;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_word_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_word_t  m_data;
    logic       cfg_we;
    logic [2:0] cfg_wdata;

    // Predicted display state
    logic [7:0] shown [DIGIT_COUNT];
    logic [2:0] radix_sel;
    out_word_t  pending_results [$];

    // Segment font for digit values 0..F
    logic [7:0] seg_font [16] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
                                  8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71};

    bit no_idle;
    int hold_len;
    int mismatches;
    int stall_cycles;
    int n_shows, n_points, n_range_errs, n_format_errs, n_format_writes;

    multi_radix_seven_segment_display i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Largest number that fits in four digits of the given format
    function automatic int unsigned radix_limit(input logic [2:0] fmt);
        case (fmt)
            FMT_DEC: return 9999;
            FMT_OCT: return 'o7777;
            FMT_BIN: return 15;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Apply one command to the predicted patterns and build its result word
    function automatic out_word_t predict_display(input in_word_t w);
        out_word_t   r;
        int unsigned base;
        int unsigned v;
        logic [1:0]  err;
        int          idx;
        err = ERR_NONE;
        if (w.cmd == CMD_SHOW) begin
            case (radix_sel)
                FMT_HEX: base = 16;
                FMT_DEC: base = 10;
                FMT_OCT: base = 8;
                FMT_BIN: base = 2;
                default: base = 0;
            endcase
            if (base == 0)
                err = ERR_FORMAT;
            else if (w.number > radix_limit(radix_sel))
                err = ERR_RANGE;
            if (err != ERR_NONE) begin
                shown[0] = GLYPH_E;
                shown[1] = GLYPH_R;
                shown[2] = GLYPH_R;
                shown[3] = (err == ERR_RANGE) ? seg_font[1] : seg_font[2];
            end else begin
                // split least significant digit first, into the rightmost slot
                v = w.number;
                for (idx = DIGIT_COUNT - 1; idx >= 0; idx--) begin
                    shown[idx] = seg_font[v % base];
                    v = v / base;
                end
            end
        end else if (w.position >= POS_1 && w.position <= POS_4) begin
            idx = w.position - 1;
            if (w.point_on)
                shown[idx] = shown[idx] | SEG_POINT;
            else
                shown[idx] = shown[idx] & ~SEG_POINT;
        end
        r.digit1_segments = shown[0];
        r.digit2_segments = shown[1];
        r.digit3_segments = shown[2];
        r.digit4_segments = shown[3];
        r.error_code      = err;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 20)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offer one word, hold it until taken, then queue its prediction
    task automatic send_word(input in_word_t w);
        int        gap;
        bit        took;
        out_word_t r;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 10)
            gap = $urandom_range(4, 1);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        r = predict_display(w);
        pending_results.push_back(r);
        if (w.cmd == CMD_SHOW)
            n_shows++;
        else
            n_points++;
        if (r.error_code == ERR_RANGE)
            n_range_errs++;
        if (r.error_code == ERR_FORMAT)
            n_format_errs++;
    endtask

    task automatic send_fields(input logic cmd, input logic [15:0] number,
                               input logic [2:0] position, input logic point_on);
        in_word_t w;
        w.cmd      = cmd;
        w.number   = number;
        w.position = position;
        w.point_on = point_on;
        send_word(w);
    endtask

    // Drain the block, then write the format register
    task automatic set_format(input logic [2:0] fmt);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= fmt;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        radix_sel = fmt;
        n_format_writes++;
    endtask

    // Mostly in-range numbers and valid positions, with some of everything else
    function automatic in_word_t random_word();
        in_word_t w;
        w.cmd = ($urandom_range(99) < 65) ? CMD_SHOW : CMD_POINT;
        if ($urandom_range(99) < 80)
            w.number = 16'($urandom_range(radix_limit(radix_sel), 0));
        else
            w.number = 16'($urandom);
        w.position = ($urandom_range(99) < 85) ? 3'($urandom_range(4, 1))
                                               : 3'($urandom_range(7, 0));
        w.point_on = 1'($urandom_range(1, 0));
        return w;
    endfunction

    function automatic logic [2:0] random_format();
        if ($urandom_range(99) < 80) begin
            case ($urandom_range(3, 0))
                0:       return FMT_HEX;
                1:       return FMT_DEC;
                2:       return FMT_OCT;
                default: return FMT_BIN;
            endcase
        end
        case ($urandom_range(3, 0))
            0:       return FMT_UNK0;
            1:       return FMT_UNK5;
            2:       return FMT_UNK6;
            default: return FMT_UNK7;
        endcase
    endfunction

    // Points on a blank display, then clears and ignored positions
    task automatic test_points_from_reset();
        send_fields(CMD_POINT, 16'hFFFF, POS_1, 1'b1);
        send_fields(CMD_POINT, 16'h0000, POS_4, 1'b1);
        send_fields(CMD_POINT, 16'h5A5A, POS_2, 1'b1);
        send_fields(CMD_POINT, 16'hA5A5, POS_3, 1'b1);
        send_fields(CMD_POINT, 16'h0000, POS_2, 1'b0);
        send_fields(CMD_POINT, 16'h0000, POS_NONE, 1'b1);
        send_fields(CMD_POINT, 16'h0000, POS_5, 1'b1);
        send_fields(CMD_POINT, 16'h0000, POS_7, 1'b0);
    endtask

    // Hex extremes; showing a number drops the points set above
    task automatic test_show_hex();
        send_fields(CMD_SHOW, 16'h0000, POS_7, 1'b1);
        send_fields(CMD_SHOW, 16'hFFFF, POS_1, 1'b0);
        send_fields(CMD_SHOW, 16'h1000, POS_2, 1'b1);
        send_fields(CMD_POINT, 16'hFFFF, POS_3, 1'b1);
    endtask

    // Range edges of decimal, octal and binary
    task automatic test_range_limits();
        set_format(FMT_DEC);
        send_fields(CMD_SHOW, 16'd9999, POS_1, 1'b1);
        send_fields(CMD_SHOW, 16'd10000, POS_1, 1'b1);
        send_fields(CMD_SHOW, 16'd1000, POS_1, 1'b0);
        send_fields(CMD_SHOW, 16'd0, POS_4, 1'b1);
        set_format(FMT_OCT);
        send_fields(CMD_SHOW, 16'o7777, POS_1, 1'b0);
        send_fields(CMD_SHOW, 16'h1000, POS_1, 1'b0);
        set_format(FMT_BIN);
        send_fields(CMD_SHOW, 16'd15, POS_1, 1'b0);
        send_fields(CMD_SHOW, 16'd16, POS_1, 1'b0);
        send_fields(CMD_SHOW, 16'hFFFF, POS_1, 1'b0);
    endtask

    // Every unknown format code, then a point over the error display
    task automatic test_unknown_formats();
        set_format(FMT_UNK0);
        send_fields(CMD_SHOW, 16'h0000, POS_1, 1'b0);
        set_format(FMT_UNK5);
        send_fields(CMD_SHOW, 16'h1234, POS_1, 1'b0);
        set_format(FMT_UNK6);
        send_fields(CMD_SHOW, 16'hFFFF, POS_1, 1'b0);
        set_format(FMT_UNK7);
        send_fields(CMD_SHOW, 16'h0001, POS_1, 1'b0);
        send_fields(CMD_POINT, 16'h0000, POS_4, 1'b1);
    endtask

    // Random words in blocks, each block under a freshly chosen format
    task automatic test_random_traffic(input int blocks, input int per_block);
        int b, k;
        for (b = 0; b < blocks; b++) begin
            set_format(random_format());
            for (k = 0; k < per_block; k++)
                send_word(random_word());
        end
    endtask

    // Back-to-back words with both sides always ready
    task automatic test_no_idle_stretch();
        no_idle = 1'b1;
        test_random_traffic(4, 50);
        no_idle = 1'b0;
    endtask

    // Hold off the receiver so the block fills and stalls its input
    task automatic test_back_pressure();
        int k;
        set_format(FMT_DEC);
        hold_len = HOLD_CYCLES;
        for (k = 0; k < 60; k++)
            send_word(random_word());
    endtask

    // Receiver: random ready, a long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_ready <= 1'b0;
                hold_len--;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 20);
            end
        end
    end

    // Result checker: sample between edges, compare with the oldest prediction
    initial begin
        out_word_t want;
        forever begin
            @(negedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result word", int'(m_data[31:0]), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.digit1_segments !== want.digit1_segments)
                        report_mismatch("digit1_segments", m_data.digit1_segments,
                                        want.digit1_segments);
                    if (m_data.digit2_segments !== want.digit2_segments)
                        report_mismatch("digit2_segments", m_data.digit2_segments,
                                        want.digit2_segments);
                    if (m_data.digit3_segments !== want.digit3_segments)
                        report_mismatch("digit3_segments", m_data.digit3_segments,
                                        want.digit3_segments);
                    if (m_data.digit4_segments !== want.digit4_segments)
                        report_mismatch("digit4_segments", m_data.digit4_segments,
                                        want.digit4_segments);
                    if (m_data.error_code !== want.error_code)
                        report_mismatch("error_code", m_data.error_code, want.error_code);
                end
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(negedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int k;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        no_idle   = 1'b0;
        hold_len  = 0;
        mismatches = 0;
        radix_sel = FMT_HEX;
        for (k = 0; k < DIGIT_COUNT; k++)
            shown[k] = 8'h00;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_points_from_reset();
        test_show_hex();
        test_range_limits();
        test_unknown_formats();
        test_random_traffic(15, 50);
        test_no_idle_stretch();
        test_back_pressure();
        test_random_traffic(15, 50);

        // Drain and let the pipeline settle
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d show-number and %0d point words over %0d format writes,",
                 n_shows, n_points, n_format_writes);
        $display("with %0d out-of-range and %0d unknown-format displays; %0d mismatches.",
                 n_range_errs, n_format_errs, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/mrssd_pkg.sv
sv/mrssd_split.sv
sv/mrssd_update.sv
sv/multi_radix_seven_segment_display.sv
sv/mrssd_checker.sv
dv/multi_radix_seven_segment_display_tb.sv
